// File: rtl/core/bia_pkg.sv
// bia_pkg: shared types, codes, widths and helpers for the bitmap index allocator
// depends on nothing; imported by bia_word_ram, bitmap_index_allocator and tb_top
package bia_pkg;

    // widths fixed by the item fields
    localparam int CMD_W  = 2;
    localparam int STAT_W = 2;
    localparam int ITEM_W = 16;
    localparam int DATA_W = 64;
    localparam int BIT_W  = 6;
    localparam int HINT_W = 10;

    // default bitmap depth in words
    localparam int WORD_COUNT_DEFAULT = 1024;

    // command codes
    typedef enum logic [CMD_W-1:0] {
        CMD_ALLOC = 2'd0,
        CMD_FREE  = 2'd1,
        CMD_LOAD  = 2'd2,
        CMD_READ  = 2'd3
    } command_t;

    // status codes
    typedef enum logic [STAT_W-1:0] {
        STAT_DONE = 2'd0,
        STAT_FULL = 2'd1,
        STAT_ROOT = 2'd2
    } status_t;

    // sequencer states
    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_SCAN,
        ST_RESP
    } state_t;

    // position of the lowest clear bit; isolate it, then encode the one-hot
    function automatic logic [BIT_W-1:0] lowest_clear(input logic [DATA_W-1:0] w);
        logic [DATA_W-1:0] inv;
        logic [DATA_W-1:0] onehot;
        logic [BIT_W-1:0]  pos;
        inv    = ~w;
        onehot = inv & (~inv + DATA_W'(1));
        pos    = '0;
        for (int b = 0; b < BIT_W; b++) begin
            for (int i = 0; i < DATA_W; i++) begin
                if (((i >> b) & 1) == 1) begin
                    pos[b] = pos[b] | onehot[i];
                end
            end
        end
        return pos;
    endfunction

endpackage

// File: rtl/core/bia_word_ram.sv
// bia_word_ram: simple dual-port bitmap word memory, one write and one registered read
// depends on bia_pkg for the data width
module bia_word_ram
    import bia_pkg::*;
#(
    parameter int DEPTH  = WORD_COUNT_DEFAULT,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
)
(
    input  logic              clk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [DATA_W-1:0] wr_data,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [DATA_W-1:0] rd_data
);

    logic [DATA_W-1:0] mem [DEPTH];
    logic [DATA_W-1:0] rd_data_reg;

    // write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // read port, registered
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// File: rtl/core/bitmap_index_allocator.sv
// bitmap_index_allocator: allocation bitmap with a next-free hint word
// depends on bia_pkg and bia_word_ram

// The allocator holds WORD_COUNT 64-bit bitmap words in one synchronous RAM
// and a 10-bit hint word. After reset a clearing pass writes every word to
// zero while in_stall stays high. One command is taken at a time: a load
// writes its word when taken and goes straight to its result beat, a free or
// a read modifies or returns its word in ST_SCAN, and an allocate stays in
// ST_SCAN reading words from the hint upward, one RAM read per cycle, until a
// word with a clear bit is found or the top of the bitmap is reached. A
// command that touches no word (refused root free, out-of-range address, hint
// beyond the bitmap) goes straight to ST_RESP. The next command is taken
// while the previous result beat is still waiting on out_stall.
module bitmap_index_allocator
    import bia_pkg::*;
#(
    parameter int WORD_COUNT = WORD_COUNT_DEFAULT
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    input  logic [CMD_W-1:0]  command,
    input  logic [ITEM_W-1:0] item_index,
    input  logic [DATA_W-1:0] word_value,
    output logic              out_valid,
    input  logic              out_stall,
    output logic [STAT_W-1:0] status,
    output logic [ITEM_W-1:0] granted_index,
    output logic [DATA_W-1:0] word_out
);

    localparam int ADDR_W = (WORD_COUNT > 1) ? $clog2(WORD_COUNT) : 1;
    localparam logic [HINT_W:0]   WORD_LIMIT = (HINT_W+1)'(WORD_COUNT);
    localparam logic [ITEM_W-1:0] IDX_LIMIT  = ITEM_W'(WORD_COUNT);
    localparam logic [ADDR_W-1:0] CLR_LAST   = ADDR_W'(WORD_COUNT - 1);
    localparam logic [DATA_W-1:0] ALL_ONES   = '1;

    state_t            state_reg, state_next;
    logic [HINT_W-1:0] hint_reg, hint_next;
    logic [HINT_W-1:0] scan_reg, scan_next;
    logic [ADDR_W-1:0] clr_reg, clr_next;
    command_t          cmd_reg, cmd_next;
    logic [BIT_W-1:0]  bit_reg, bit_next;

    logic [STAT_W-1:0] pend_status_reg, pend_status_next;
    logic [ITEM_W-1:0] pend_granted_reg, pend_granted_next;
    logic [DATA_W-1:0] pend_word_reg, pend_word_next;

    logic              out_valid_reg, out_valid_next;
    logic [STAT_W-1:0] status_reg;
    logic [ITEM_W-1:0] granted_reg;
    logic [DATA_W-1:0] word_out_reg;
    logic              out_load;

    logic              wr_en;
    logic [ADDR_W-1:0] wr_addr;
    logic [DATA_W-1:0] wr_data;
    logic              rd_en;
    logic [ADDR_W-1:0] rd_addr;
    logic [DATA_W-1:0] rd_data;

    logic              accept;
    command_t          in_cmd;
    logic [HINT_W-1:0] in_word;
    logic [BIT_W-1:0]  clear_pos;
    logic [DATA_W-1:0] alloc_word;
    logic [HINT_W:0]   scan_inc;

    bia_word_ram #(
        .DEPTH  (WORD_COUNT),
        .ADDR_W (ADDR_W)
    ) u_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // decode of the incoming beat and the scanned word
    assign in_stall   = (state_reg != ST_IDLE);
    assign accept     = in_valid && (state_reg == ST_IDLE);
    assign in_cmd     = command_t'(command);
    assign in_word    = item_index[ITEM_W-1:BIT_W];
    assign clear_pos  = lowest_clear(rd_data);
    assign alloc_word = rd_data | (DATA_W'(1) << clear_pos);
    assign scan_inc   = {1'b0, scan_reg} + (HINT_W+1)'(1);

    // sequencer state and working registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
            hint_reg  <= '0;
            clr_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            hint_reg  <= hint_next;
            clr_reg   <= clr_next;
        end
    end

    always_ff @(posedge clk)
    begin
        scan_reg         <= scan_next;
        cmd_reg          <= cmd_next;
        bit_reg          <= bit_next;
        pend_status_reg  <= pend_status_next;
        pend_granted_reg <= pend_granted_next;
        pend_word_reg    <= pend_word_next;
    end

    // next state, ram accesses and pending result
    always_comb
    begin
        state_next        = state_reg;
        hint_next         = hint_reg;
        scan_next         = scan_reg;
        clr_next          = clr_reg;
        cmd_next          = cmd_reg;
        bit_next          = bit_reg;
        pend_status_next  = pend_status_reg;
        pend_granted_next = pend_granted_reg;
        pend_word_next    = pend_word_reg;
        wr_en             = 1'b0;
        wr_addr           = scan_reg[ADDR_W-1:0];
        wr_data           = '0;
        rd_en             = 1'b0;
        rd_addr           = scan_reg[ADDR_W-1:0];
        out_load          = 1'b0;

        unique case (state_reg)
            // zero every word after reset
            ST_CLEAR:
            begin
                wr_en   = 1'b1;
                wr_addr = clr_reg;
                wr_data = '0;
                clr_next = clr_reg + ADDR_W'(1);
                if (clr_reg == CLR_LAST)
                begin
                    state_next = ST_IDLE;
                end
            end

            // take a command and start its ram access
            ST_IDLE:
            begin
                if (accept)
                begin
                    cmd_next          = in_cmd;
                    bit_next          = item_index[BIT_W-1:0];
                    pend_status_next  = STAT_DONE;
                    pend_granted_next = '0;
                    pend_word_next    = '0;
                    state_next        = ST_RESP;
                    unique case (in_cmd)
                        CMD_ALLOC:
                        begin
                            if ({1'b0, hint_reg} >= WORD_LIMIT)
                            begin
                                pend_status_next = STAT_FULL;
                            end
                            else
                            begin
                                rd_en      = 1'b1;
                                rd_addr    = hint_reg[ADDR_W-1:0];
                                scan_next  = hint_reg;
                                state_next = ST_SCAN;
                            end
                        end
                        CMD_FREE:
                        begin
                            if (item_index == '0)
                            begin
                                pend_status_next = STAT_ROOT;
                            end
                            else if ({1'b0, in_word} < WORD_LIMIT)
                            begin
                                rd_en      = 1'b1;
                                rd_addr    = in_word[ADDR_W-1:0];
                                scan_next  = in_word;
                                state_next = ST_SCAN;
                            end
                        end
                        CMD_LOAD:
                        begin
                            if (item_index < IDX_LIMIT)
                            begin
                                wr_en   = 1'b1;
                                wr_addr = item_index[ADDR_W-1:0];
                                wr_data = word_value;
                                if ((word_value != ALL_ONES) &&
                                    (hint_reg > item_index[HINT_W-1:0]))
                                begin
                                    hint_next = item_index[HINT_W-1:0];
                                end
                            end
                        end
                        CMD_READ:
                        begin
                            if (item_index < IDX_LIMIT)
                            begin
                                rd_en      = 1'b1;
                                rd_addr    = item_index[ADDR_W-1:0];
                                scan_next  = item_index[HINT_W-1:0];
                                state_next = ST_SCAN;
                            end
                        end
                        default:
                        begin
                            state_next = ST_RESP;
                        end
                    endcase
                end
            end

            // word of scan_reg is on rd_data: modify and write back, capture it, or step on
            ST_SCAN:
            begin
                state_next = ST_RESP;
                case (cmd_reg)
                    CMD_ALLOC:
                    begin
                        if (rd_data != ALL_ONES)
                        begin
                            wr_en             = 1'b1;
                            wr_data           = alloc_word;
                            pend_granted_next = {scan_reg, clear_pos};
                            if (alloc_word == ALL_ONES)
                            begin
                                hint_next = hint_reg + HINT_W'(1);
                            end
                        end
                        else if (scan_inc >= WORD_LIMIT)
                        begin
                            pend_status_next = STAT_FULL;
                        end
                        else
                        begin
                            rd_en      = 1'b1;
                            rd_addr    = scan_inc[ADDR_W-1:0];
                            scan_next  = scan_inc[HINT_W-1:0];
                            state_next = ST_SCAN;
                        end
                    end
                    CMD_FREE:
                    begin
                        wr_en   = 1'b1;
                        wr_data = rd_data & ~(DATA_W'(1) << bit_reg);
                        if (hint_reg > scan_reg)
                        begin
                            hint_next = scan_reg;
                        end
                    end
                    CMD_READ:
                    begin
                        pend_word_next = rd_data;
                    end
                    default:
                    begin
                        pend_status_next = STAT_DONE;
                    end
                endcase
            end

            // hand the result to the output register once it is free
            ST_RESP:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_load   = 1'b1;
                    state_next = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // output beat register
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            status_reg   <= pend_status_reg;
            granted_reg  <= pend_granted_reg;
            word_out_reg <= pend_word_reg;
        end
    end

    assign out_valid     = out_valid_reg;
    assign status        = status_reg;
    assign granted_index = granted_reg;
    assign word_out      = word_out_reg;

endmodule

// File: bench/tb_top.sv
// tb_top: self-checking bench for bitmap_index_allocator, with a shadow bitmap that predicts
// every reply beat and random idling on both channels
// depends on bia_pkg and the bitmap_index_allocator rtl
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import bia_pkg::*;

    localparam int                WORDS      = WORD_COUNT_DEFAULT;
    localparam int                IDLE_LIMIT = 8000;
    localparam int                RAND_BEATS = 200;
    localparam int                TOP_SHORT  = 4;
    localparam logic [DATA_W-1:0] FULL_WORD  = '1;

    // one expected reply beat
    typedef struct {
        status_t           st;
        logic [ITEM_W-1:0] grant;
        logic [DATA_W-1:0] word;
    } reply_t;

    // shadow copy of the bitmap and hint, plus the replies still owed by the block
    class bitmap_shadow;
        logic [DATA_W-1:0] usage [WORDS];
        logic [HINT_W-1:0] hint;
        reply_t            owed [$];
        int                mismatches;

        function new();
            foreach (usage[i])
            begin
                usage[i] = '0;
            end
            hint       = '0;
            mismatches = 0;
        endfunction

        // apply one accepted command and queue the reply it should produce
        function void take_command(command_t cmd, logic [ITEM_W-1:0] idx,
                                   logic [DATA_W-1:0] val);
            reply_t r;
            int     w;
            int     k;
            bit     hit;
            r.st    = STAT_DONE;
            r.grant = '0;
            r.word  = '0;
            case (cmd)
                CMD_ALLOC:
                begin
                    // first word from the hint upward with a clear bit
                    hit = 1'b0;
                    for (w = int'(hint); w < WORDS; w++)
                    begin
                        if (usage[w] != FULL_WORD)
                        begin
                            hit = 1'b1;
                            break;
                        end
                    end
                    if (!hit)
                    begin
                        r.st = STAT_FULL;
                    end
                    else
                    begin
                        for (k = 0; k < DATA_W; k++)
                        begin
                            if (!usage[w][k])
                            begin
                                break;
                            end
                        end
                        usage[w][k] = 1'b1;
                        r.grant     = ITEM_W'(w * DATA_W + k);
                        if (usage[w] == FULL_WORD)
                        begin
                            hint = hint + 1'b1;
                        end
                    end
                end
                CMD_FREE:
                begin
                    if (idx == '0)
                    begin
                        r.st = STAT_ROOT;
                    end
                    else
                    begin
                        w = int'(idx >> BIT_W);
                        if (w < WORDS)
                        begin
                            usage[w][idx[BIT_W-1:0]] = 1'b0;
                            if (int'(hint) > w)
                            begin
                                hint = HINT_W'(w);
                            end
                        end
                    end
                end
                CMD_LOAD:
                begin
                    if (int'(idx) < WORDS)
                    begin
                        usage[idx] = val;
                        if (val != FULL_WORD && int'(hint) > int'(idx))
                        begin
                            hint = HINT_W'(idx);
                        end
                    end
                end
                default:
                begin
                    if (int'(idx) < WORDS)
                    begin
                        r.word = usage[idx];
                    end
                end
            endcase
            owed.push_back(r);
        endfunction

        // compare one reply beat with the oldest owed reply
        function void check_reply(logic [STAT_W-1:0] st, logic [ITEM_W-1:0] grant,
                                  logic [DATA_W-1:0] word);
            reply_t e;
            if (owed.size() == 0)
            begin
                $error("unexpected reply beat: status %0d, granted_index %0d, word_out %h",
                       st, grant, word);
                mismatches++;
                return;
            end
            e = owed.pop_front();
            if (st !== e.st)
            begin
                $error("status: expected %0d, got %0d", e.st, st);
                mismatches++;
            end
            if (grant !== e.grant)
            begin
                $error("granted_index: expected %0d, got %0d", e.grant, grant);
                mismatches++;
            end
            if (word !== e.word)
            begin
                $error("word_out: expected %h, got %h", e.word, word);
                mismatches++;
            end
        endfunction
    endclass

    logic              clk;
    logic              rst_n      = 1'b0;
    logic              in_valid   = 1'b0;
    logic              in_stall;
    logic [CMD_W-1:0]  command    = CMD_ALLOC;
    logic [ITEM_W-1:0] item_index = '0;
    logic [DATA_W-1:0] word_value = '0;
    logic              out_valid;
    logic              out_stall  = 1'b0;
    logic [STAT_W-1:0] status;
    logic [ITEM_W-1:0] granted_index;
    logic [DATA_W-1:0] word_out;

    bitmap_shadow shadow = new();

    bit calm_in   = 1'b0;
    bit calm_out  = 1'b0;
    int out_hold  = 0;
    int idle_cycles = 0;

    bitmap_index_allocator #(
        .WORD_COUNT (WORDS)
    ) dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .command       (command),
        .item_index    (item_index),
        .word_value    (word_value),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .status        (status),
        .granted_index (granted_index),
        .word_out      (word_out)
    );

    // 100 MHz clock
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // idle length: mostly short, now and then long
    function automatic int pick_gap();
        int r;
        r = $urandom_range(99);
        if (r < 80)
        begin
            return $urandom_range(3);
        end
        else if (r < 96)
        begin
            return $urandom_range(10, 4);
        end
        return $urandom_range(60, 20);
    endfunction

    // receiver back-pressure
    always @(posedge clk)
    begin
        if (out_hold != 0)
        begin
            out_stall <= 1'b1;
            out_hold  <= out_hold - 1;
        end
        else if (!calm_out && $urandom_range(3) == 0)
        begin
            out_stall <= 1'b1;
            out_hold  <= pick_gap();
        end
        else
        begin
            out_stall <= 1'b0;
        end
    end

    // reply beat checking
    always @(posedge clk)
    begin
        if (rst_n && out_valid === 1'b1 && out_stall === 1'b0)
        begin
            shadow.check_reply(status, granted_index, word_out);
        end
    end

    // watchdog on cycles with no beat on either channel
    always @(posedge clk)
    begin
        if ((in_valid && in_stall === 1'b0) || (out_valid === 1'b1 && !out_stall))
        begin
            idle_cycles <= 0;
        end
        else
        begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("bitmap_index_allocator verification failed");
            $finish;
        end
    end

    // present one command beat, with an optional gap first, and hold it until taken
    task automatic send_beat(command_t cmd, logic [ITEM_W-1:0] idx, logic [DATA_W-1:0] val);
        int gap;
        gap = (calm_in || $urandom_range(2) != 0) ? 0 : pick_gap();
        if (gap != 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid   <= 1'b1;
        command    <= cmd;
        item_index <= idx;
        word_value <= val;
        do
            @(posedge clk);
        while (in_stall !== 1'b0);
        shadow.take_command(cmd, idx, val);
    endtask

    // stop sending and hold off until every owed reply has come back
    task automatic drain();
        in_valid <= 1'b0;
        while (shadow.owed.size() != 0)
        begin
            @(posedge clk);
        end
    endtask

    // one random command, mostly aimed at the low span of words
    task automatic random_command(int span);
        int                r;
        logic [ITEM_W-1:0] idx;
        logic [ITEM_W-1:0] addr;
        logic [DATA_W-1:0] val;
        r    = $urandom_range(99);
        idx  = ITEM_W'($urandom_range(span * DATA_W - 1));
        addr = ($urandom_range(9) == 0) ? ITEM_W'($urandom_range(65535, WORDS))
                                        : ITEM_W'($urandom_range(span - 1));
        val  = {$urandom, $urandom};
        if (r < 40)
        begin
            send_beat(CMD_ALLOC, ITEM_W'($urandom), val);
        end
        else if (r < 65)
        begin
            case ($urandom_range(9))
                0: idx = '0;
                1: idx = ITEM_W'($urandom);
                default: ;
            endcase
            send_beat(CMD_FREE, idx, val);
        end
        else if (r < 80)
        begin
            // load contents: random, full, one bit clear, or mostly ones
            case ($urandom_range(3))
                0: ;
                1: val = FULL_WORD;
                2: val = FULL_WORD ^ (DATA_W'(1) << $urandom_range(DATA_W - 1));
                default: val = ~({$urandom, $urandom} & {$urandom, $urandom}
                                 & {$urandom, $urandom});
            endcase
            send_beat(CMD_LOAD, addr, val);
        end
        else
        begin
            send_beat(CMD_READ, addr, val);
        end
    endtask

    // stimulus
    initial
    begin
        int                span;
        logic [ITEM_W-1:0] victim;
        span = 1;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        // directed: grants, root refusal, hint lowering, extremes and out-of-range words
        send_beat(CMD_READ,  ITEM_W'(0), '0);
        send_beat(CMD_ALLOC, '0, '0);
        send_beat(CMD_ALLOC, '1, FULL_WORD);
        send_beat(CMD_FREE,  ITEM_W'(0), '0);
        send_beat(CMD_FREE,  ITEM_W'(1), '0);
        send_beat(CMD_ALLOC, '0, '0);
        send_beat(CMD_FREE,  ITEM_W'(5 * DATA_W + 7), '0);
        send_beat(CMD_LOAD,  ITEM_W'(0), 64'h7FFF_FFFF_FFFF_FFFF);
        send_beat(CMD_ALLOC, '0, '0);
        send_beat(CMD_LOAD,  ITEM_W'(0), 64'hFFFF_FFFF_FFFF_FFFE);
        send_beat(CMD_ALLOC, '0, '0);
        send_beat(CMD_FREE,  ITEM_W'(5), '0);
        send_beat(CMD_ALLOC, '0, '0);
        send_beat(CMD_ALLOC, '0, '0);
        send_beat(CMD_LOAD,  ITEM_W'(WORDS - 1), FULL_WORD);
        send_beat(CMD_READ,  ITEM_W'(WORDS - 1), '0);
        send_beat(CMD_LOAD,  ITEM_W'(WORDS), FULL_WORD);
        send_beat(CMD_READ,  ITEM_W'(WORDS), '0);
        send_beat(CMD_LOAD,  '1, 64'hA5A5_5A5A_C3C3_3C3C);
        send_beat(CMD_READ,  '1, '0);
        send_beat(CMD_FREE,  '1, '0);
        send_beat(CMD_READ,  ITEM_W'(WORDS - 1), '0);
        send_beat(CMD_LOAD,  ITEM_W'(WORDS - 1), '0);
        send_beat(CMD_LOAD,  ITEM_W'(0), '0);
        drain();

        // random mix over a shifting span of low words
        for (int n = 0; n < RAND_BEATS; n++)
        begin
            if (n % 150 == 0)
            begin
                span = ($urandom_range(7) == 0) ? 64 : (1 << $urandom_range(3));
            end
            if (n % 100 == 0)
            begin
                calm_in  = ($urandom_range(3) == 0);
                calm_out = ($urandom_range(3) == 0);
            end
            if ($urandom_range(99) == 0)
            begin
                drain();
            end
            random_command(span);
        end
        calm_in  = 1'b0;
        calm_out = 1'b0;
        drain();

        // sweep: every word full but the top few, one bit short there, so allocs scan far
        for (int w = 0; w < WORDS; w++)
        begin
            if ($urandom_range(15) == 0)
            begin
                send_beat(CMD_READ, ITEM_W'($urandom_range(WORDS - 1)), {$urandom, $urandom});
            end
            send_beat(CMD_LOAD, ITEM_W'(w),
                      (w < WORDS - TOP_SHORT) ? FULL_WORD
                      : FULL_WORD ^ (DATA_W'(1) << $urandom_range(DATA_W - 1)));
        end
        for (int w = 0; w < TOP_SHORT; w++)
        begin
            send_beat(CMD_ALLOC, ITEM_W'($urandom), '0);
        end

        // full bitmap: refusals, then single frees that must be granted straight back
        send_beat(CMD_ALLOC, '0, '0);
        send_beat(CMD_FREE,  ITEM_W'(0), '0);
        repeat (8)
        begin
            victim = ITEM_W'($urandom_range(65535, 1));
            send_beat(CMD_FREE,  victim, '0);
            send_beat(CMD_ALLOC, '0, '0);
            send_beat(CMD_ALLOC, '0, '0);
            send_beat(CMD_READ,  victim >> BIT_W, '0);
        end

        // let any stray beat show up before the verdict
        drain();
        repeat (WORDS + 16) @(posedge clk);
        if (shadow.mismatches == 0 && shadow.owed.size() == 0)
        begin
            $display("bitmap_index_allocator verification clean");
        end
        else
        begin
            $display("bitmap_index_allocator verification failed");
        end
        $finish;
    end

endmodule

// File: bitmap_index_allocator.f
rtl/core/bia_pkg.sv
rtl/core/bia_word_ram.sv
rtl/core/bitmap_index_allocator.sv
bench/tb_top.sv
